[rtl/bx2rc_pkg.sv]
// Shared types and constants of the 2x bilinear residual compose block.
package bx2rc_pkg;

  localparam int POS_W     = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CHAN_W    = 8;
  localparam int RES_W     = 16;
  localparam int TAP_W     = 12;
  localparam int SUM_W     = 12;
  localparam int N_W       = 25;
  localparam int PROD_W    = 37;

  // Interpolated sums are in sixteenths of a byte: full scale 255 * 16.
  localparam int SUM_SCALE = 4080;
  localparam int SUM_MAX   = 4080;
  // One in the corrected domain: SUM_SCALE * 2^13.
  localparam int CORR_ONE  = 33423360;
  // Half of CORR_ONE * 16, for round half up.
  localparam int HALF_DEN  = 267386880;
  // CORR_ONE * 16 = 255 * 2^21.
  localparam int QUO_SH    = 21;

  localparam logic [CFG_W-1:0] LOW_WIDTH_RESET  = 11'd960;
  localparam logic [CFG_W-1:0] LOW_HEIGHT_RESET = 11'd540;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_HEIGHT = 1'b1;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPOSE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     operation;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [CHAN_W-1:0]       in_blue;
    logic [CHAN_W-1:0]       in_green;
    logic [CHAN_W-1:0]       in_red;
    logic [CHAN_W-1:0]       in_alpha;
    logic signed [RES_W-1:0] residual_red;
    logic signed [RES_W-1:0] residual_green;
    logic signed [RES_W-1:0] residual_blue;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_alpha;
  } out_item_t;

  // Stored word: B in the low byte, A in the high byte.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  localparam int PIX_W = $bits(pixel_t);

  typedef struct packed {
    logic signed [RES_W-1:0] red;
    logic signed [RES_W-1:0] green;
    logic signed [RES_W-1:0] blue;
  } res_t;

  // Bank of top and bottom rows, and which neighbour carries weight 3/4.
  typedef struct packed {
    logic top_odd;
    logic bot_odd;
    logic x_odd;
    logic y_odd;
  } sel_t;

  typedef struct packed {
    logic [SUM_W-1:0] sb;
    logic [SUM_W-1:0] sg;
    logic [SUM_W-1:0] sr;
    logic [SUM_W-1:0] sa;
  } sums_t;

endpackage

[rtl/bx2rc_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
module bx2rc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/bx2rc_interp.sv]
// Bilinear 1/4-3/4 blend of the four neighbour pixels into sixteenth-scale sums.
module bx2rc_interp (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  bx2rc_pkg::sel_t   sel,
  input  bx2rc_pkg::res_t   res,
  input  bx2rc_pkg::pixel_t even_a,
  input  bx2rc_pkg::pixel_t even_b,
  input  bx2rc_pkg::pixel_t odd_a,
  input  bx2rc_pkg::pixel_t odd_b,
  output logic              sum_valid,
  output bx2rc_pkg::sums_t  sums,
  output bx2rc_pkg::res_t   sum_res
);

  // near_a: first operand takes 3/4
  function automatic logic [9:0] mix_px(input logic [7:0] a, input logic [7:0] b,
                                        input logic near_a);
    logic [9:0] r;
    if (near_a) begin
      r = 10'({a, 1'b0}) + 10'(a) + 10'(b);
    end else begin
      r = 10'(a) + 10'({b, 1'b0}) + 10'(b);
    end
    return r;
  endfunction

  function automatic logic [11:0] mix_row(input logic [9:0] a, input logic [9:0] b,
                                          input logic near_a);
    logic [11:0] r;
    if (near_a) begin
      r = 12'({a, 1'b0}) + 12'(a) + 12'(b);
    end else begin
      r = 12'(a) + 12'({b, 1'b0}) + 12'(b);
    end
    return r;
  endfunction

  function automatic logic [11:0] chan(input logic [7:0] c00, input logic [7:0] c10,
                                       input logic [7:0] c01, input logic [7:0] c11,
                                       input logic xo, input logic yo);
    logic [9:0] t;
    logic [9:0] b;
    t = mix_px(c00, c10, xo);
    b = mix_px(c01, c11, xo);
    return mix_row(t, b, yo);
  endfunction

  bx2rc_pkg::pixel_t p00, p10, p01, p11;
  bx2rc_pkg::sums_t  sums_next;

  always_comb begin
    p00 = sel.top_odd ? odd_a : even_a;
    p10 = sel.top_odd ? odd_b : even_b;
    p01 = sel.bot_odd ? odd_a : even_a;
    p11 = sel.bot_odd ? odd_b : even_b;
    sums_next.sb = chan(p00.blue,  p10.blue,  p01.blue,  p11.blue,  sel.x_odd, sel.y_odd);
    sums_next.sg = chan(p00.green, p10.green, p01.green, p11.green, sel.x_odd, sel.y_odd);
    sums_next.sr = chan(p00.red,   p10.red,   p01.red,   p11.red,   sel.x_odd, sel.y_odd);
    sums_next.sa = chan(p00.alpha, p10.alpha, p01.alpha, p11.alpha, sel.x_odd, sel.y_odd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else begin
      sum_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    sums    <= sums_next;
    sum_res <= res;
  end

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> (sums.sa <= bx2rc_pkg::SUM_W'(bx2rc_pkg::SUM_MAX)
                && sums.sr <= bx2rc_pkg::SUM_W'(bx2rc_pkg::SUM_MAX)
                && sums.sg <= bx2rc_pkg::SUM_W'(bx2rc_pkg::SUM_MAX)
                && sums.sb <= bx2rc_pkg::SUM_W'(bx2rc_pkg::SUM_MAX)))
    else $error("interpolated sum above full scale");

endmodule

[rtl/bx2rc_correct.sv]
// Residual correction, clamp, alpha premultiply and rounding of one composed pixel.
module bx2rc_correct (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  input  bx2rc_pkg::sums_t     sums,
  input  bx2rc_pkg::res_t      res,
  output logic                 done,
  output bx2rc_pkg::out_item_t result
);

  localparam int NW = bx2rc_pkg::N_W;
  localparam int PW = bx2rc_pkg::PROD_W;

  // sum/4080 + r/8192 clamped to [0,1], scaled by 4080 * 8192
  function automatic logic [NW-1:0] corr(input logic [bx2rc_pkg::SUM_W-1:0] s,
                                         input logic signed [bx2rc_pkg::RES_W-1:0] r);
    logic signed [28:0] n;
    logic [NW-1:0]      q;
    n = $signed({4'b0, s, 13'b0})
      + $signed({{13{r[bx2rc_pkg::RES_W-1]}}, r}) * 29'(bx2rc_pkg::SUM_SCALE);
    if (n[28]) begin
      q = '0;
    end else if (n > 29'(bx2rc_pkg::CORR_ONE)) begin
      q = NW'(bx2rc_pkg::CORR_ONE);
    end else begin
      q = n[NW-1:0];
    end
    return q;
  endfunction

  // round(p / (255 * 2^21)); v / 255 via reciprocal with correction, v < 2^16
  function automatic logic [7:0] quot(input logic [PW-1:0] p);
    logic [PW-1:0] t;
    logic [15:0]   v;
    logic [16:0]   s;
    t = p + PW'(bx2rc_pkg::HALF_DEN);
    v = 16'(t >> bx2rc_pkg::QUO_SH);
    s = 17'(v) + 17'(v[15:8]) + 17'd1;
    return (s[16:8] > 9'd255) ? 8'd255 : s[15:8];
  endfunction

  logic                        n_valid;
  logic [NW-1:0]               n_b, n_g, n_r;
  logic [bx2rc_pkg::SUM_W-1:0] n_sa;
  logic [7:0]                  n_alpha;
  logic [12:0]                 alpha_rnd;

  logic                        p_valid;
  logic [PW-1:0]               p_b, p_g, p_r;
  logic [7:0]                  p_alpha;

  assign alpha_rnd = 13'(sums.sa) + 13'd8;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
      p_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      n_valid <= valid;
      p_valid <= n_valid;
      done    <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    n_b     <= corr(sums.sb, res.blue);
    n_g     <= corr(sums.sg, res.green);
    n_r     <= corr(sums.sr, res.red);
    n_sa    <= sums.sa;
    n_alpha <= alpha_rnd[11:4];

    p_b     <= PW'(n_b) * PW'(n_sa);
    p_g     <= PW'(n_g) * PW'(n_sa);
    p_r     <= PW'(n_r) * PW'(n_sa);
    p_alpha <= n_alpha;

    result.out_blue  <= quot(p_b);
    result.out_green <= quot(p_g);
    result.out_red   <= quot(p_r);
    result.out_alpha <= p_alpha;
  end

  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    n_valid |-> (n_b <= NW'(bx2rc_pkg::CORR_ONE) && n_g <= NW'(bx2rc_pkg::CORR_ONE)
              && n_r <= NW'(bx2rc_pkg::CORR_ONE)))
    else $error("corrected channel outside [0,1]");

  a_premult: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_blue <= result.out_alpha && result.out_green <= result.out_alpha
           && result.out_red <= result.out_alpha))
    else $error("premultiplied colour exceeds alpha");

endmodule

[rtl/bilinear_x2_residual_compose.sv]
// Top level: frame store banks, neighbour addressing and the compose pipeline.
//
// Takes one transfer per clock, writes and composes alike; busy is never raised.
// A write produces no result. A compose produces one result, registered in turn
// in s0, the bank read, the sums, the corrected and premultiplied values and in
// result with done. Results leave in request order and must be taken when shown.
// One compose per cycle is possible because the store is split into even-row
// and odd-row banks, each with two read ports, so the four neighbours come out
// of a single access. Reading a location never written returns undefined data;
// there is no clearing pass. Writes outside MAX_WIDTH x MAX_HEIGHT are dropped.
// Change low_width and low_height only while no compose is in flight.
module bilinear_x2_residual_compose #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  bx2rc_pkg::in_item_t                 item,
  output logic                                done,
  output bx2rc_pkg::out_item_t                result,
  input  logic                                cfg_we,
  input  logic [bx2rc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bx2rc_pkg::CFG_W-1:0]         cfg_data
);

  localparam int BANK_DEPTH = ((MAX_HEIGHT + 1) / 2) * MAX_WIDTH;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam int TW         = bx2rc_pkg::TAP_W;
  localparam int LW         = TW + 1;
  localparam int PW         = bx2rc_pkg::POS_W;
  localparam int LATENCY    = 6;

  function automatic logic [TW-1:0] tap_lo(input logic [PW-1:0] pos,
                                           input logic [TW-1:0] last);
    logic [TW-1:0] h;
    logic [TW-1:0] r;
    h = TW'(pos[PW-1:1]);
    if (pos[0]) begin
      r = h;
    end else if (h == '0) begin
      r = '0;
    end else begin
      r = h - TW'(1);
    end
    return (r > last) ? last : r;
  endfunction

  function automatic logic [TW-1:0] tap_hi(input logic [PW-1:0] pos,
                                           input logic [TW-1:0] last);
    logic [TW-1:0] h;
    logic [TW-1:0] r;
    h = TW'(pos[PW-1:1]);
    r = pos[0] ? h + TW'(1) : h;
    return (r > last) ? last : r;
  endfunction

  function automatic logic [AW-1:0] word_addr(input logic [TW-1:0] row,
                                              input logic [TW-1:0] col);
    return AW'(row[TW-1:1]) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  logic [bx2rc_pkg::CFG_W-1:0] low_width, low_height;
  logic                        s0_valid;
  bx2rc_pkg::in_item_t         s0_item;
  logic                        s1_valid;
  bx2rc_pkg::sel_t             s1_sel;
  bx2rc_pkg::res_t             s1_res;

  logic [LW-1:0]     wd, ht;
  logic [TW-1:0]     last_x, last_y;
  logic [TW-1:0]     x0, x1, y0, y1, row_e, row_o;
  logic              wr_ok, we_even, we_odd;
  logic [AW-1:0]     waddr;
  bx2rc_pkg::pixel_t wdata;
  bx2rc_pkg::sel_t   sel;
  bx2rc_pkg::res_t   res;
  bx2rc_pkg::pixel_t even_a, even_b, odd_a, odd_b;

  logic              sum_valid;
  bx2rc_pkg::sums_t  sums;
  bx2rc_pkg::res_t   sum_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_width  <= bx2rc_pkg::LOW_WIDTH_RESET;
      low_height <= bx2rc_pkg::LOW_HEIGHT_RESET;
      s0_valid   <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bx2rc_pkg::CFG_LOW_WIDTH:  low_width  <= cfg_data;
          bx2rc_pkg::CFG_LOW_HEIGHT: low_height <= cfg_data;
        endcase
      end
      s0_valid <= start && !busy;
      s1_valid <= s0_valid && s0_item.operation == bx2rc_pkg::OP_COMPOSE;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s0_item <= item;
    end
    s1_sel <= sel;
    s1_res <= res;
  end

  // last valid index after limiting the size registers to [1, MAX]
  always_comb begin
    wd = LW'(low_width);
    ht = LW'(low_height);
    if (wd == '0) begin
      last_x = '0;
    end else if (wd > LW'(MAX_WIDTH)) begin
      last_x = TW'(MAX_WIDTH - 1);
    end else begin
      last_x = TW'(wd - LW'(1));
    end
    if (ht == '0) begin
      last_y = '0;
    end else if (ht > LW'(MAX_HEIGHT)) begin
      last_y = TW'(MAX_HEIGHT - 1);
    end else begin
      last_y = TW'(ht - LW'(1));
    end
  end

  always_comb begin
    x0    = tap_lo(s0_item.pos_x, last_x);
    x1    = tap_hi(s0_item.pos_x, last_x);
    y0    = tap_lo(s0_item.pos_y, last_y);
    y1    = tap_hi(s0_item.pos_y, last_y);
    // rows differ in parity unless clamped to one row
    row_e = y0[0] ? y1 : y0;
    row_o = y0[0] ? y0 : y1;

    sel.top_odd = y0[0];
    sel.bot_odd = y1[0];
    sel.x_odd   = s0_item.pos_x[0];
    sel.y_odd   = s0_item.pos_y[0];

    res.red   = s0_item.residual_red;
    res.green = s0_item.residual_green;
    res.blue  = s0_item.residual_blue;

    wr_ok   = s0_valid && s0_item.operation == bx2rc_pkg::OP_WRITE
           && LW'(s0_item.pos_x) < LW'(MAX_WIDTH) && LW'(s0_item.pos_y) < LW'(MAX_HEIGHT);
    we_even = wr_ok && !s0_item.pos_y[0];
    we_odd  = wr_ok && s0_item.pos_y[0];
    waddr   = word_addr(TW'(s0_item.pos_y), TW'(s0_item.pos_x));

    wdata.blue  = s0_item.in_blue;
    wdata.green = s0_item.in_green;
    wdata.red   = s0_item.in_red;
    wdata.alpha = s0_item.in_alpha;
  end

  bx2rc_ram #(
    .WIDTH (bx2rc_pkg::PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk     (clk),
    .we      (we_even),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (word_addr(row_e, x0)),
    .raddr_b (word_addr(row_e, x1)),
    .rdata_a (even_a),
    .rdata_b (even_b)
  );

  bx2rc_ram #(
    .WIDTH (bx2rc_pkg::PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk     (clk),
    .we      (we_odd),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (word_addr(row_o, x0)),
    .raddr_b (word_addr(row_o, x1)),
    .rdata_a (odd_a),
    .rdata_b (odd_b)
  );

  bx2rc_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .valid     (s1_valid),
    .sel       (s1_sel),
    .res       (s1_res),
    .even_a    (even_a),
    .even_b    (even_b),
    .odd_a     (odd_a),
    .odd_b     (odd_b),
    .sum_valid (sum_valid),
    .sums      (sums),
    .sum_res   (sum_res)
  );

  bx2rc_correct u_correct (
    .clk    (clk),
    .rst    (rst),
    .valid  (sum_valid),
    .sums   (sums),
    .res    (sum_res),
    .done   (done),
    .result (result)
  );

  a_compose_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == bx2rc_pkg::OP_COMPOSE) |-> ##LATENCY done)
    else $error("compose transfer without result");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && item.operation == bx2rc_pkg::OP_COMPOSE, LATENCY))
    else $error("result without compose transfer");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    (we_even || we_odd) |=> !s1_valid)
    else $error("store write and neighbour fetch in one cycle");

endmodule
